// ===== sv/syslog_message_escaper_defines.svh =====
// assertion macros shared by the escaper
`ifndef SYSLOG_MESSAGE_ESCAPER_DEFINES_SVH
`define SYSLOG_MESSAGE_ESCAPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SME_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("syslog escaper: assertion failed");

// next-cycle implication, checked outside reset
`define SME_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("syslog escaper: assertion failed");

`endif

// ===== sv/sme_pkg.sv =====
package sme_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [9:0] priority_res;
        logic       last_of_run;
    } t_res_item;

    localparam int RUN_MAX = 3;

    typedef struct packed {
        logic [1:0]                  num;
        t_res_item [RUN_MAX-1:0]     items;
    } t_run;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_AFTER_LT = 3'd1,
        MODE_DIGITS   = 3'd2,
        MODE_TEXT     = 3'd3
    } t_mode;

    localparam logic       KIND_TEXT   = 1'b0;
    localparam logic       KIND_END    = 1'b1;

    localparam logic [9:0] PRI_DEFAULT = 10'd13;
    localparam logic [9:0] PRI_ZERO    = 10'd0;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CTRL_MAX    = 8'h1F;
    localparam logic [7:0] ESC_OFFSET  = 8'h40;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] DIGIT_SPAN  = 8'd9;
    localparam logic [7:0] ALPHA_SPAN  = 8'd25;

    function automatic logic is_digit(input logic [7:0] b);
        logic [7:0] t;
        t = b - CHAR_ZERO;
        return t <= DIGIT_SPAN;
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        logic [7:0] t;
        t = (b | CASE_BIT) - CHAR_LOW_A;
        return is_digit(b) || (t <= ALPHA_SPAN);
    endfunction

    // anything above 1023 falls back to the default priority
    function automatic logic [9:0] clamp_pri(input logic [63:0] v);
        return (|v[63:10]) ? PRI_DEFAULT : v[9:0];
    endfunction

endpackage

// ===== sv/sme_in_buf.sv =====
module sme_in_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sme_pkg::t_in_item   i_data,
    output logic                o_head_valid,
    output sme_pkg::t_in_item   o_head,
    input  logic                i_take
);

    sme_pkg::t_in_item r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              n_wr_ptr;
    logic              n_rd_ptr;
    logic [1:0]        n_cnt;
    logic              push;
    logic              pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = i_take && o_head_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/sme_parse.sv =====
module sme_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  sme_pkg::t_in_item   i_item,
    output sme_pkg::t_run       o_run
);

    sme_pkg::t_mode r_mode;
    sme_pkg::t_mode n_mode;
    logic [63:0]    r_value;
    logic [63:0]    n_value;
    logic           r_ovf;
    logic           n_ovf;
    logic [9:0]     r_pri;
    logic [9:0]     n_pri;

    logic [7:0]     b;
    logic           b_digit;
    logic           b_alnum;
    logic [7:0]     digit;
    logic [67:0]    acc;
    logic           emit_en;
    logic [7:0]     c;
    logic           esc;
    logic [1:0]     tcount;
    logic           end_en;
    logic [9:0]     end_pri;
    logic [1:0]     num;
    sme_pkg::t_res_item text_item [2];
    sme_pkg::t_res_item end_item;

    assign b       = i_item.data_byte;
    assign b_digit = sme_pkg::is_digit(b);
    assign b_alnum = sme_pkg::is_alnum(b);
    assign digit   = b - sme_pkg::CHAR_ZERO;
    // value * 10 + digit, carry bits flag a 64-bit overflow
    assign acc = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) + {60'b0, digit};

    always_comb begin
        n_mode  = r_mode;
        n_value = r_value;
        n_ovf   = r_ovf;
        n_pri   = r_pri;
        emit_en = 1'b0;
        end_en  = 1'b0;
        end_pri = r_pri;
        unique case (r_mode)
            sme_pkg::MODE_START: begin
                n_pri = sme_pkg::PRI_DEFAULT;
                if (b == sme_pkg::CHAR_NUL) begin
                    end_en  = 1'b1;
                    end_pri = sme_pkg::PRI_DEFAULT;
                end else if (b == sme_pkg::CHAR_LT) begin
                    n_mode = sme_pkg::MODE_AFTER_LT;
                end else begin
                    n_mode  = sme_pkg::MODE_TEXT;
                    emit_en = 1'b1;
                end
            end
            sme_pkg::MODE_AFTER_LT: begin
                if (b_digit) begin
                    n_value = {56'b0, digit};
                    n_ovf   = 1'b0;
                    n_mode  = sme_pkg::MODE_DIGITS;
                end else begin
                    n_pri = sme_pkg::PRI_ZERO;
                    if (b == sme_pkg::CHAR_NUL) begin
                        end_en  = 1'b1;
                        end_pri = sme_pkg::PRI_ZERO;
                    end else begin
                        n_mode  = sme_pkg::MODE_TEXT;
                        emit_en = (b != sme_pkg::CHAR_GT);
                    end
                end
            end
            sme_pkg::MODE_DIGITS: begin
                if (b_digit) begin
                    if (!r_ovf) begin
                        if (|acc[67:64]) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_value = acc[63:0];
                        end
                    end
                end else if (b == sme_pkg::CHAR_NUL) begin
                    end_en  = 1'b1;
                    end_pri = r_ovf ? sme_pkg::PRI_DEFAULT : sme_pkg::clamp_pri(r_value);
                end else begin
                    n_pri   = (b_alnum || r_ovf) ? sme_pkg::PRI_ZERO
                                                 : sme_pkg::clamp_pri(r_value);
                    n_mode  = sme_pkg::MODE_TEXT;
                    emit_en = (b != sme_pkg::CHAR_GT);
                end
            end
            default: begin
                if (b == sme_pkg::CHAR_NUL) begin
                    end_en = 1'b1;
                end else begin
                    n_mode  = sme_pkg::MODE_TEXT;
                    emit_en = 1'b1;
                end
            end
        endcase

        // end of datagram closes an open message with the updated state
        if (i_item.last_byte && (b != sme_pkg::CHAR_NUL)) begin
            end_en = 1'b1;
            priority case (n_mode)
                sme_pkg::MODE_AFTER_LT: end_pri = sme_pkg::PRI_ZERO;
                sme_pkg::MODE_DIGITS:   end_pri = n_ovf ? sme_pkg::PRI_DEFAULT
                                                        : sme_pkg::clamp_pri(n_value);
                default:                end_pri = n_pri;
            endcase
        end

        if (end_en) begin
            n_mode  = sme_pkg::MODE_START;
            n_value = 64'd0;
            n_ovf   = 1'b0;
            n_pri   = sme_pkg::PRI_DEFAULT;
        end
    end

    // text escaping
    always_comb begin
        c   = (b == sme_pkg::CHAR_LF) ? sme_pkg::CHAR_SPACE : b;
        esc = (c <= sme_pkg::CTRL_MAX) && (c != sme_pkg::CHAR_TAB);
        tcount = emit_en ? (esc ? 2'd2 : 2'd1) : 2'd0;
        num    = tcount + {1'b0, end_en};

        text_item[0].kind         = sme_pkg::KIND_TEXT;
        text_item[0].out_byte     = esc ? sme_pkg::CHAR_CARET : c;
        text_item[0].priority_res = 10'd0;
        text_item[0].last_of_run  = 1'b0;
        text_item[1].kind         = sme_pkg::KIND_TEXT;
        text_item[1].out_byte     = c + sme_pkg::ESC_OFFSET;
        text_item[1].priority_res = 10'd0;
        text_item[1].last_of_run  = 1'b0;
        end_item.kind             = sme_pkg::KIND_END;
        end_item.out_byte         = 8'd0;
        end_item.priority_res     = end_pri;
        end_item.last_of_run      = 1'b0;

        o_run.num = num;
        for (int i = 0; i < sme_pkg::RUN_MAX; i++) begin
            if (i < 2 && 2'(i) < tcount) begin
                o_run.items[i] = text_item[i[0]];
            end else begin
                o_run.items[i] = end_item;
            end
            o_run.items[i].last_of_run = (2'(i + 1) == num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sme_pkg::MODE_START;
            r_value <= 64'd0;
            r_ovf   <= 1'b0;
            r_pri   <= sme_pkg::PRI_DEFAULT;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_value <= n_value;
            r_ovf   <= n_ovf;
            r_pri   <= n_pri;
        end
    end

endmodule

// ===== sv/sme_run_buf.sv =====
module sme_run_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  sme_pkg::t_run       i_run,
    output logic                o_load_ok,
    output logic                o_valid,
    input  logic                i_ready,
    output sme_pkg::t_res_item  o_data
);

    sme_pkg::t_res_item r_items [sme_pkg::RUN_MAX];
    logic [1:0]         r_num;
    logic               pop;

    assign o_valid   = (r_num != 2'd0);
    assign o_data    = r_items[0];
    assign pop       = o_valid && i_ready;
    // room for a new run once the last pending result leaves
    assign o_load_ok = (r_num == 2'd0) || ((r_num == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else if (o_load_ok && i_take) begin
            r_num <= i_run.num;
        end else if (pop) begin
            r_num <= r_num - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_take) begin
            for (int i = 0; i < sme_pkg::RUN_MAX; i++) begin
                r_items[i] <= i_run.items[i];
            end
        end else if (pop) begin
            for (int i = 0; i < sme_pkg::RUN_MAX - 1; i++) begin
                r_items[i] <= r_items[i+1];
            end
        end
    end

endmodule

// ===== sv/syslog_message_escaper.sv =====
// path: input buffer register, combinational parser, run buffer register
// throughput: one byte per cycle while each byte gives at most one result and i_ready is
// high; a longer run holds off the next byte until it has left the three-entry run buffer
// a two-entry input buffer keeps input ready registered
// reset: synchronous, active low; empties both buffers and returns the parser to
// message start with priority 13
`include "syslog_message_escaper_defines.svh"

module syslog_message_escaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sme_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sme_pkg::t_res_item  o_data
);

    logic               head_valid;
    sme_pkg::t_in_item  head;
    logic               load_ok;
    logic               take;
    sme_pkg::t_run      run;
    logic               out_end;
    logic               out_text;

    assign take = head_valid && load_ok;

    assign out_end  = o_valid && (o_data.kind == sme_pkg::KIND_END);
    assign out_text = o_valid && (o_data.kind == sme_pkg::KIND_TEXT);

    sme_in_buf u_in_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_take       (take)
    );

    sme_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (head),
        .o_run   (run)
    );

    sme_run_buf u_run_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_run     (run),
        .o_load_ok (load_ok),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    // an end-of-message result always closes its run
    `SME_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, out_end, o_data.last_of_run)
    // text results carry no priority and end results carry no byte
    `SME_ASSERT_IMP(a_text_no_pri, i_clk, i_rst_n, out_text, o_data.priority_res == 10'd0)
    `SME_ASSERT_IMP(a_end_no_byte, i_clk, i_rst_n, out_end, o_data.out_byte == 8'd0)
    // a taken result that is not the end of its run is followed by another valid result
    `SME_ASSERT_NXT(a_run_continues, i_clk, i_rst_n, o_valid && i_ready && !o_data.last_of_run, o_valid)

endmodule

// ===== tb/sv/tb_syslog_message_escaper.sv =====
`timescale 1ns / 1ps

module tb_syslog_message_escaper;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RESET_LEN   = 11;
    localparam int          RANDOM_LEN  = 130;
    localparam int          LONG_HOLD   = 120;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [63:0] PRIO_MAX    = 64'd1023;

    typedef struct packed {
        sme_pkg::t_in_item        stim;
        logic                     fixed;
        logic [1:0]               n_fixed;
        sme_pkg::t_res_item [2:0] fixed_res;
    } t_dir_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    sme_pkg::t_in_item  i_data  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    sme_pkg::t_res_item o_data;

    syslog_message_escaper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser state of the predictor
    sme_pkg::t_mode esc_mode = sme_pkg::MODE_START;
    logic [63:0]    prio_acc = '0;
    logic           prio_ovf = 1'b0;
    logic [9:0]     msg_prio = sme_pkg::PRI_DEFAULT;

    sme_pkg::t_res_item byte_run[$];
    sme_pkg::t_res_item due_results[$];
    t_dir_row           dir_tab[$];
    sme_pkg::t_res_item want;

    int          n_bytes    = 0;
    int          n_seen     = 0;
    int          n_ends     = 0;
    int          n_fail     = 0;
    int          burst_left = 0;
    int          rx_cyc     = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;
    int unsigned cyc_cnt    = 0;
    int          stop_at;

    function automatic sme_pkg::t_res_item mk_res(input logic kind, input logic [7:0] b,
                                                  input logic [9:0] pri, input logic lst);
        sme_pkg::t_res_item r;
        r.kind         = kind;
        r.out_byte     = b;
        r.priority_res = pri;
        r.last_of_run  = lst;
        return r;
    endfunction

    function automatic sme_pkg::t_in_item mk_in(input logic [7:0] b, input logic lst);
        sme_pkg::t_in_item it;
        it.data_byte = b;
        it.last_byte = lst;
        return it;
    endfunction

    function automatic t_dir_row dir_row(input logic [7:0] b, input logic lst,
                                         input logic fixed, input logic [1:0] n,
                                         input sme_pkg::t_res_item r0,
                                         input sme_pkg::t_res_item r1,
                                         input sme_pkg::t_res_item r2);
        t_dir_row row;
        row.stim         = mk_in(b, lst);
        row.fixed        = fixed;
        row.n_fixed      = n;
        row.fixed_res[0] = r0;
        row.fixed_res[1] = r1;
        row.fixed_res[2] = r2;
        return row;
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        logic [7:0] lc;
        lc = b | sme_pkg::CASE_BIT;
        return is_dec(b) || (lc >= "a" && lc <= "z");
    endfunction

    function automatic logic [9:0] prio_of(input logic [63:0] v);
        return (v > PRIO_MAX) ? sme_pkg::PRI_DEFAULT : v[9:0];
    endfunction

    function automatic void put_text(input logic [7:0] c);
        logic [7:0] ch;
        ch = (c == sme_pkg::CHAR_LF) ? sme_pkg::CHAR_SPACE : c;
        if (ch <= sme_pkg::CTRL_MAX && ch != sme_pkg::CHAR_TAB) begin
            byte_run.push_back(mk_res(sme_pkg::KIND_TEXT, sme_pkg::CHAR_CARET,
                                      sme_pkg::PRI_ZERO, 1'b0));
            ch = ch + sme_pkg::ESC_OFFSET;
        end
        byte_run.push_back(mk_res(sme_pkg::KIND_TEXT, ch, sme_pkg::PRI_ZERO, 1'b0));
    endfunction

    function automatic void close_msg();
        byte_run.push_back(mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL, msg_prio, 1'b0));
        esc_mode = sme_pkg::MODE_START;
        prio_acc = '0;
        prio_ovf = 1'b0;
        msg_prio = sme_pkg::PRI_DEFAULT;
    endfunction

    function automatic void parse_one(input logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - sme_pkg::CHAR_ZERO);
        case (esc_mode)
            sme_pkg::MODE_START: begin
                msg_prio = sme_pkg::PRI_DEFAULT;
                if (b == sme_pkg::CHAR_NUL) begin
                    close_msg();
                end else if (b == sme_pkg::CHAR_LT) begin
                    esc_mode = sme_pkg::MODE_AFTER_LT;
                end else begin
                    esc_mode = sme_pkg::MODE_TEXT;
                    put_text(b);
                end
            end
            sme_pkg::MODE_AFTER_LT: begin
                if (is_dec(b)) begin
                    prio_acc = d;
                    prio_ovf = 1'b0;
                    esc_mode = sme_pkg::MODE_DIGITS;
                end else begin
                    msg_prio = sme_pkg::PRI_ZERO;
                    if (b == sme_pkg::CHAR_NUL) begin
                        close_msg();
                    end else begin
                        esc_mode = sme_pkg::MODE_TEXT;
                        if (b != sme_pkg::CHAR_GT) put_text(b);
                    end
                end
            end
            sme_pkg::MODE_DIGITS: begin
                if (is_dec(b)) begin
                    if (!prio_ovf) begin
                        if (prio_acc > ({64{1'b1}} - d) / 64'd10) prio_ovf = 1'b1;
                        else prio_acc = prio_acc * 64'd10 + d;
                    end
                end else if (b == sme_pkg::CHAR_NUL) begin
                    // end of message keeps a number up to 1023, a larger one or overflow falls back to default
                    msg_prio = prio_ovf ? sme_pkg::PRI_DEFAULT : prio_of(prio_acc);
                    close_msg();
                end else begin
                    if (is_word(b) || prio_ovf) msg_prio = sme_pkg::PRI_ZERO;
                    else msg_prio = prio_of(prio_acc);
                    esc_mode = sme_pkg::MODE_TEXT;
                    if (b != sme_pkg::CHAR_GT) put_text(b);
                end
            end
            default: begin
                if (b == sme_pkg::CHAR_NUL) begin
                    close_msg();
                end else begin
                    esc_mode = sme_pkg::MODE_TEXT;
                    put_text(b);
                end
            end
        endcase
    endfunction

    function automatic void escape_byte(input sme_pkg::t_in_item it);
        sme_pkg::t_res_item r;
        byte_run.delete();
        parse_one(it.data_byte);
        // end of datagram closes the message unless a nul already did
        if (it.last_byte && it.data_byte != sme_pkg::CHAR_NUL) parse_one(sme_pkg::CHAR_NUL);
        if (byte_run.size() > 0) begin
            r = byte_run.pop_back();
            r.last_of_run = 1'b1;
            byte_run.push_back(r);
        end
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(1, 31));
            1: return sme_pkg::CHAR_LF;
            2: return 8'($urandom_range(127, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic push_byte(input sme_pkg::t_in_item it, input logic fixed,
                             input logic [1:0] n_fixed,
                             input sme_pkg::t_res_item [2:0] fixed_res);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        escape_byte(it);
        if (fixed) begin
            for (int k = 0; k < n_fixed; k++) due_results.push_back(fixed_res[k]);
        end else begin
            foreach (byte_run[k]) due_results.push_back(byte_run[k]);
        end
        n_bytes++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic play_message();
        sme_pkg::t_in_item msg[$];
        sme_pkg::t_in_item it;
        int                n;
        logic [7:0]        b;
        if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) != 0) begin
                msg.push_back(mk_in(sme_pkg::CHAR_LT, 1'b0));
                // now and then long enough to overflow 64 bits
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(19, 24) : $urandom_range(0, 4);
                repeat (n)
                    msg.push_back(mk_in(sme_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0));
                case ($urandom_range(0, 4))
                    0, 1: msg.push_back(mk_in(sme_pkg::CHAR_GT, 1'b0));
                    2: begin
                        b = (sme_pkg::CHAR_LOW_A + 8'($urandom_range(0, 25)))
                            ^ ($urandom_range(0, 1) ? sme_pkg::CASE_BIT : 8'h00);
                        msg.push_back(mk_in(b, 1'b0));
                    end
                    3: msg.push_back(mk_in(text_byte(), 1'b0));
                    default: ;
                endcase
            end
            repeat ($urandom_range(0, 8)) msg.push_back(mk_in(text_byte(), 1'b0));
            if ($urandom_range(0, 1)) begin
                msg.push_back(mk_in(sme_pkg::CHAR_NUL, $urandom_range(0, 3) == 0));
            end else if (msg.size() == 0) begin
                msg.push_back(mk_in(text_byte(), 1'b1));
            end else begin
                it = msg.pop_back();
                it.last_byte = 1'b1;
                msg.push_back(it);
            end
        end else begin
            repeat ($urandom_range(1, 10))
                msg.push_back(mk_in(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
        end
        foreach (msg[k]) push_byte(msg[k], 1'b0, 2'd0, '0);
    endtask

    // receiver: changing stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_seen >= 40) begin
            i_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            case (rx_cyc[7:6])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= $urandom_range(0, 1);
                2'd2: i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: %h", o_data);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                if (o_data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_data.kind);
                    n_fail++;
                end
                if (o_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_data.out_byte);
                    n_fail++;
                end
                if (o_data.priority_res !== want.priority_res) begin
                    $error("priority_res: expected %0d, got %0d",
                           want.priority_res, o_data.priority_res);
                    n_fail++;
                end
                if (o_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_data.last_of_run);
                    n_fail++;
                end
                n_seen <= n_seen + 1;
                if (want.kind == sme_pkg::KIND_END) n_ends <= n_ends + 1;
            end
        end
    end

    initial begin
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        // leading and back-to-back nuls, escapes, high bytes, three results from one byte
        dir_tab.push_back(dir_row(sme_pkg::CHAR_NUL, 1'b0, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL,
                                         sme_pkg::PRI_DEFAULT, 1'b1), '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_NUL, 1'b0, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL,
                                         sme_pkg::PRI_DEFAULT, 1'b1), '0, '0));
        dir_tab.push_back(dir_row(8'h01, 1'b0, 1'b1, 2'd2,
                                  mk_res(sme_pkg::KIND_TEXT, sme_pkg::CHAR_CARET,
                                         sme_pkg::PRI_ZERO, 1'b0),
                                  mk_res(sme_pkg::KIND_TEXT, 8'h41, sme_pkg::PRI_ZERO, 1'b1),
                                  '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LF, 1'b0, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_TEXT, sme_pkg::CHAR_SPACE,
                                         sme_pkg::PRI_ZERO, 1'b1), '0, '0));
        dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_TEXT, 8'hFF, sme_pkg::PRI_ZERO, 1'b1),
                                  '0, '0));
        dir_tab.push_back(dir_row(8'h7F, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_TAB, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CTRL_MAX, 1'b1, 1'b1, 2'd3,
                                  mk_res(sme_pkg::KIND_TEXT, sme_pkg::CHAR_CARET,
                                         sme_pkg::PRI_ZERO, 1'b0),
                                  mk_res(sme_pkg::KIND_TEXT, 8'h5F, sme_pkg::PRI_ZERO, 1'b0),
                                  mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL,
                                         sme_pkg::PRI_DEFAULT, 1'b1)));
        // '<' straight into a nul
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_NUL, 1'b0, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL,
                                         sme_pkg::PRI_ZERO, 1'b1), '0, '0));
        // digits closed by the end of the datagram
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("9", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("9", 1'b1, 1'b0, 2'd0, '0, '0, '0));
        // priority above the limit, then a trailing nul
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("2", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("0", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("4", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("8", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_GT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_NUL, 1'b1, 1'b1, 2'd1,
                                  mk_res(sme_pkg::KIND_END, sme_pkg::CHAR_NUL,
                                         sme_pkg::PRI_DEFAULT, 1'b1), '0, '0));
        // digits cut short by a letter
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("7", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row("q", 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_LT, 1'b0, 1'b0, 2'd0, '0, '0, '0));
        dir_tab.push_back(dir_row(sme_pkg::CHAR_NUL, 1'b0, 1'b0, 2'd0, '0, '0, '0));

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r])
            push_byte(dir_tab[r].stim, dir_tab[r].fixed, dir_tab[r].n_fixed,
                      dir_tab[r].fixed_res);

        stop_at = n_bytes + RANDOM_LEN;
        while (n_bytes < stop_at) play_message();
        i_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d bytes, closed %0d messages, checked %0d results",
                 n_bytes, n_ends, n_seen);
        $display("mix of priority headers, overflowing numbers, escapes, noise and one long stall");
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== syslog_message_escaper.f =====
+incdir+sv
sv/sme_pkg.sv
sv/sme_in_buf.sv
sv/sme_parse.sv
sv/sme_run_buf.sv
sv/syslog_message_escaper.sv
tb/sv/tb_syslog_message_escaper.sv
